/* design/epcal_pkg.sv */
package epcal_pkg;

   localparam int DATA_W = 32;
   localparam int REG_ADDR_W = 3;
   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_ZONE_OFFSET = 1'b0;

   localparam int EPOCH_W = 40;
   localparam int ZONE_W = 17;
   localparam int YEAR_W = 16;
   localparam int MONTH_W = 4;
   localparam int DOM_W = 5;
   localparam int DOY_W = 9;
   localparam int HOUR_W = 5;
   localparam int MIN_W = 6;

   localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd28800;

   localparam int SECS_PER_DAY = 86400;
   localparam int DAYS_1970_TO_2001 = 11323;
   localparam int DAYS_400Y = 146097;
   localparam int DAYS_100Y = 36524;
   localparam int DAYS_4Y = 1461;
   localparam int DAYS_1Y = 365;
   localparam int BASE_YEAR = 2001;
   localparam int CYCLE_BIAS = 44;

   localparam int TIME_W = 41;
   localparam logic [TIME_W-1:0] TIME_BIAS =
      TIME_W'(longint'(SECS_PER_DAY) * longint'(CYCLE_BIAS * DAYS_400Y - DAYS_1970_TO_2001));
   localparam logic [YEAR_W-1:0] YEAR_BASE = YEAR_W'(BASE_YEAR - 400 * CYCLE_BIAS);

   localparam int SOD_LO_W = 7;
   localparam int SOD_HI_DIV = SECS_PER_DAY / (1 << SOD_LO_W);
   localparam int SOD_HI_W = 10;
   localparam int SOD_W = SOD_HI_W + SOD_LO_W;
   localparam int DAYS_W = 24;
   localparam int Q400_W = 7;
   localparam int R400_W = 18;
   localparam int R100_W = 16;
   localparam int Q4_W = 5;
   localparam int R4_W = 11;
   localparam int MOD_W = 11;
   localparam int MIN_DIV_W = 4;

   localparam logic [DOY_W-1:0] MONTH_START [2][12] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
        9'd304, 9'd334},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
        9'd305, 9'd335}
   };

   function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                    input logic [MONTH_W-1:0] idx);
      logic [DOY_W-1:0] start_day;
      if (idx > 4'd11) begin
         start_day = '0;
      end else begin
         start_day = MONTH_START[leap][idx];
      end
      return start_day;
   endfunction

endpackage

/* design/epoch_seconds_to_calendar_core.sv */
// Epoch seconds to calendar date and time of day.
//
// Input: pulse start with req_epoch_seconds (signed seconds since 1970-01-01
// 00:00 UTC). busy is always low, so a transaction is taken on every cycle
// that start is high.
// Output: rsp_valid is high for one cycle with year, month, day of month,
// day of year, hour and minute of the local time. Every transaction gives
// exactly one result, in order.
// Throughput is one transaction per cycle. Each transaction passes through
// the offset adder, the chain of restoring divider stages (days, 400-year
// cycles, 4-year periods, minutes and hours), each retiring up to six
// quotient bits per stage, and the calendar stages between them, into the
// result register.
// The receiver cannot stall; results are presented once and not held.
// Configuration: zone offset at byte address 0 of the APB port, written
// while the pipeline is empty. Reset empties the pipeline and sets the
// offset to 28800 seconds.
module epoch_seconds_to_calendar_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [epcal_pkg::EPOCH_W-1:0]  req_epoch_seconds,
   output logic                                 rsp_valid,
   output logic signed [epcal_pkg::YEAR_W-1:0]   rsp_year,
   output logic [epcal_pkg::MONTH_W-1:0]         rsp_month,
   output logic [epcal_pkg::DOM_W-1:0]           rsp_day_of_month,
   output logic [epcal_pkg::DOY_W-1:0]           rsp_day_of_year,
   output logic [epcal_pkg::HOUR_W-1:0]          rsp_hour,
   output logic [epcal_pkg::MIN_W-1:0]           rsp_minute,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [epcal_pkg::REG_ADDR_W-1:0]      paddr,
   input  logic [epcal_pkg::DATA_W-1:0]          pwdata,
   output logic [epcal_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);
   import epcal_pkg::*;

   localparam int P3_SW = YEAR_W + 1 + SOD_W;
   localparam int P4_SW = YEAR_W + DOY_W + 1;
   localparam int P5_SW = YEAR_W + DOY_W + 1 + MONTH_W;

   logic [ZONE_W-1:0] zone_offset;

   epcal_csr u_csr (
      .clock               (clock),
      .reset               (reset),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready),
      .zone_offset_seconds (zone_offset)
   );

   assign busy = 1'b0;

   // offset input, biased so that all later arithmetic is unsigned
   logic              s0_valid_ff;
   logic [TIME_W-1:0] s0_time_ff;
   logic [TIME_W-1:0] s0_time_in;

   assign s0_time_in = {req_epoch_seconds[EPOCH_W-1], req_epoch_seconds}
                     + {{(TIME_W-ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset}
                     + TIME_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_time_ff <= s0_time_in;
   end

   // days and seconds of day
   logic                p1_valid;
   logic [DAYS_W-1:0]   p1_quot;
   logic [SOD_HI_W-1:0] p1_rem;
   logic [SOD_LO_W-1:0] p1_side;

   epcal_div_pipe #(
      .DW (TIME_W - SOD_LO_W), .QW (DAYS_W), .RW (SOD_HI_W),
      .DIVISOR (SOD_HI_DIV), .STEPS (6), .SW (SOD_LO_W)
   ) u_div_day (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s0_valid_ff),
      .in_dividend (s0_time_ff[TIME_W-1:SOD_LO_W]),
      .in_side     (s0_time_ff[SOD_LO_W-1:0]),
      .out_valid   (p1_valid),
      .out_quot    (p1_quot),
      .out_rem     (p1_rem),
      .out_side    (p1_side)
   );

   // 400-year cycles
   logic              p2_valid;
   logic [Q400_W-1:0] p2_quot;
   logic [R400_W-1:0] p2_rem;
   logic [SOD_W-1:0]  p2_sod;

   epcal_div_pipe #(
      .DW (DAYS_W), .QW (Q400_W), .RW (R400_W),
      .DIVISOR (DAYS_400Y), .STEPS (4), .SW (SOD_W)
   ) u_div_400y (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (p1_valid),
      .in_dividend (p1_quot),
      .in_side     ({p1_rem, p1_side}),
      .out_valid   (p2_valid),
      .out_quot    (p2_quot),
      .out_rem     (p2_rem),
      .out_side    (p2_sod)
   );

   // 100-year periods, clamped to three
   logic              c1_valid_ff;
   logic [R100_W-1:0] c1_r2_ff;
   logic [YEAR_W-1:0] c1_year_ff;
   logic              c1_cent3_ff;
   logic [SOD_W-1:0]  c1_sod_ff;
   logic [1:0]        q100;
   logic [R100_W-1:0] c1_r2_in;
   logic [YEAR_W-1:0] c1_year_in;

   always_comb begin
      q100 = {1'b0, p2_rem >= R400_W'(DAYS_100Y)}
           + {1'b0, p2_rem >= R400_W'(2 * DAYS_100Y)}
           + {1'b0, p2_rem >= R400_W'(3 * DAYS_100Y)};
      c1_r2_in = R100_W'(p2_rem - R400_W'(int'(q100) * DAYS_100Y));
      c1_year_in = YEAR_BASE + YEAR_W'(int'(p2_quot) * 400) + YEAR_W'(int'(q100) * 100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= p2_valid;
      end
   end

   always_ff @(posedge clock) begin
      c1_r2_ff    <= c1_r2_in;
      c1_year_ff  <= c1_year_in;
      c1_cent3_ff <= (q100 == 2'd3);
      c1_sod_ff   <= p2_sod;
   end

   // 4-year periods
   logic             p3_valid;
   logic [Q4_W-1:0]  p3_quot;
   logic [R4_W-1:0]  p3_rem;
   logic [P3_SW-1:0] p3_side;

   epcal_div_pipe #(
      .DW (R100_W), .QW (Q4_W), .RW (R4_W),
      .DIVISOR (DAYS_4Y), .STEPS (5), .SW (P3_SW)
   ) u_div_4y (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c1_valid_ff),
      .in_dividend (c1_r2_ff),
      .in_side     ({c1_year_ff, c1_cent3_ff, c1_sod_ff}),
      .out_valid   (p3_valid),
      .out_quot    (p3_quot),
      .out_rem     (p3_rem),
      .out_side    (p3_side)
   );

   // single years, clamped to three; leap flag and day of year
   logic              c2_valid_ff;
   logic [YEAR_W-1:0] c2_year_ff;
   logic [DOY_W-1:0]  c2_doy_ff;
   logic              c2_leap_ff;
   logic [SOD_W-1:0]  c2_sod_ff;
   logic [1:0]        q1;
   logic [YEAR_W-1:0] p3_year;
   logic              p3_cent3;
   logic [SOD_W-1:0]  p3_sod;
   logic [YEAR_W-1:0] c2_year_in;
   logic [DOY_W-1:0]  c2_doy_in;
   logic              c2_leap_in;

   assign p3_year  = p3_side[P3_SW-1 -: YEAR_W];
   assign p3_cent3 = p3_side[SOD_W];
   assign p3_sod   = p3_side[SOD_W-1:0];

   always_comb begin
      q1 = {1'b0, p3_rem >= R4_W'(DAYS_1Y)}
         + {1'b0, p3_rem >= R4_W'(2 * DAYS_1Y)}
         + {1'b0, p3_rem >= R4_W'(3 * DAYS_1Y)};
      c2_doy_in  = DOY_W'(p3_rem - R4_W'(int'(q1) * DAYS_1Y));
      c2_leap_in = (q1 == 2'd3) && ((p3_quot != Q4_W'(24)) || p3_cent3);
      c2_year_in = p3_year + YEAR_W'(int'(p3_quot) * 4) + YEAR_W'(q1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_valid_ff <= 1'b0;
      end else begin
         c2_valid_ff <= p3_valid;
      end
   end

   always_ff @(posedge clock) begin
      c2_year_ff <= c2_year_in;
      c2_doy_ff  <= c2_doy_in;
      c2_leap_ff <= c2_leap_in;
      c2_sod_ff  <= p3_sod;
   end

   // minute of day
   logic             p4_valid;
   logic [MOD_W-1:0] p4_quot;
   logic [P4_SW-1:0] p4_side;

   epcal_div_pipe #(
      .DW (SOD_W - 2), .QW (MOD_W), .RW (MIN_DIV_W),
      .DIVISOR (15), .STEPS (6), .SW (P4_SW)
   ) u_div_minute (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c2_valid_ff),
      .in_dividend (c2_sod_ff[SOD_W-1:2]),
      .in_side     ({c2_year_ff, c2_doy_ff, c2_leap_ff}),
      .out_valid   (p4_valid),
      .out_quot    (p4_quot),
      .out_rem     (),
      .out_side    (p4_side)
   );

   // month index from the cumulative month table
   logic               c3_valid_ff;
   logic [MOD_W-1:0]   c3_mod_ff;
   logic [P4_SW-1:0]   c3_side_ff;
   logic [MONTH_W-1:0] c3_month_ff;
   logic [MONTH_W-1:0] c3_month_in;
   logic [DOY_W-1:0]   p4_doy;
   logic               p4_leap;

   assign p4_doy  = p4_side[DOY_W:1];
   assign p4_leap = p4_side[0];

   always_comb begin
      c3_month_in = '0;
      for (int k = 1; k < 12; k++) begin
         c3_month_in = c3_month_in
                     + MONTH_W'(p4_doy >= month_start(p4_leap, MONTH_W'(k)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_valid_ff <= 1'b0;
      end else begin
         c3_valid_ff <= p4_valid;
      end
   end

   always_ff @(posedge clock) begin
      c3_mod_ff   <= p4_quot;
      c3_side_ff  <= p4_side;
      c3_month_ff <= c3_month_in;
   end

   // hour and minute
   logic               p5_valid;
   logic [HOUR_W-1:0]  p5_quot;
   logic [MIN_W-1:0]   p5_rem;
   logic [P5_SW-1:0]   p5_side;
   logic [YEAR_W-1:0]  p5_year;
   logic [DOY_W-1:0]   p5_doy;
   logic               p5_leap;
   logic [MONTH_W-1:0] p5_month;

   epcal_div_pipe #(
      .DW (MOD_W), .QW (HOUR_W), .RW (MIN_W),
      .DIVISOR (60), .STEPS (5), .SW (P5_SW)
   ) u_div_hour (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c3_valid_ff),
      .in_dividend (c3_mod_ff),
      .in_side     ({c3_side_ff, c3_month_ff}),
      .out_valid   (p5_valid),
      .out_quot    (p5_quot),
      .out_rem     (p5_rem),
      .out_side    (p5_side)
   );

   assign p5_year  = p5_side[P5_SW-1 -: YEAR_W];
   assign p5_doy   = p5_side[MONTH_W+1 +: DOY_W];
   assign p5_leap  = p5_side[MONTH_W];
   assign p5_month = p5_side[MONTH_W-1:0];

   // result register
   logic               rsp_valid_ff;
   logic [YEAR_W-1:0]  rsp_year_ff;
   logic [MONTH_W-1:0] rsp_month_ff;
   logic [DOM_W-1:0]   rsp_dom_ff;
   logic [DOY_W-1:0]   rsp_doy_ff;
   logic [HOUR_W-1:0]  rsp_hour_ff;
   logic [MIN_W-1:0]   rsp_minute_ff;
   logic [DOM_W-1:0]   rsp_dom_in;
   logic [DOY_W-1:0]   dom_w;

   always_comb begin
      dom_w      = p5_doy - month_start(p5_leap, p5_month);
      rsp_dom_in = DOM_W'(dom_w + DOY_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p5_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_year_ff   <= p5_year;
      rsp_month_ff  <= p5_month + MONTH_W'(1);
      rsp_dom_ff    <= rsp_dom_in;
      rsp_doy_ff    <= p5_doy + DOY_W'(1);
      rsp_hour_ff   <= p5_quot;
      rsp_minute_ff <= p5_rem;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = $signed(rsp_year_ff);
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_dom_ff;
   assign rsp_day_of_year  = rsp_doy_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;

endmodule

/* design/epcal_csr.sv */
module epcal_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [epcal_pkg::REG_ADDR_W-1:0] paddr,
   input  logic [epcal_pkg::DATA_W-1:0]     pwdata,
   output logic [epcal_pkg::DATA_W-1:0]     prdata,
   output logic                            pready,
   output logic [epcal_pkg::ZONE_W-1:0]     zone_offset_seconds
);
   import epcal_pkg::*;

   logic [ZONE_W-1:0] zone_ff;
   logic [ZONE_W-1:0] zone_in;
   logic              sel_zone;

   assign sel_zone = (paddr[REG_ADDR_W-1:2] == REG_ZONE_OFFSET);

   always_comb begin
      zone_in = zone_ff;
      if (psel && penable && pwrite && sel_zone) begin
         zone_in = pwdata[ZONE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else begin
         zone_ff <= zone_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_zone) begin
         prdata = {{(DATA_W-ZONE_W){zone_ff[ZONE_W-1]}}, zone_ff};
      end
   end

   assign pready = 1'b1;
   assign zone_offset_seconds = zone_ff;

endmodule

/* design/epcal_div_pipe.sv */
module epcal_div_pipe #(
   parameter int DW = 34,
   parameter int QW = 24,
   parameter int RW = 10,
   parameter int DIVISOR = 675,
   parameter int STEPS = 6,
   parameter int SW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_dividend,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [RW-1:0] out_rem,
   output logic [SW-1:0] out_side
);
   localparam int NSTG = (QW + STEPS - 1) / STEPS;
   localparam logic [RW:0] DIV_W = (RW+1)'(DIVISOR);

   logic          valid_ff [NSTG];
   logic [RW-1:0] rem_ff   [NSTG];
   logic [QW-1:0] work_ff  [NSTG];
   logic [SW-1:0] side_ff  [NSTG];

   logic          valid_at [NSTG];
   logic [RW-1:0] rem_at   [NSTG];
   logic [QW-1:0] work_at  [NSTG];
   logic [SW-1:0] side_at  [NSTG];

   logic [RW-1:0] rem_in   [NSTG];
   logic [QW-1:0] work_in  [NSTG];

   logic [RW-1:0] rem_w;
   logic [QW-1:0] work_w;
   logic [RW:0]   trial;

   always_comb begin
      valid_at[0] = in_valid;
      rem_at[0]   = RW'(in_dividend[DW-1:QW]);
      work_at[0]  = in_dividend[QW-1:0];
      side_at[0]  = in_side;
      for (int s = 1; s < NSTG; s++) begin
         valid_at[s] = valid_ff[s-1];
         rem_at[s]   = rem_ff[s-1];
         work_at[s]  = work_ff[s-1];
         side_at[s]  = side_ff[s-1];
      end
   end

   // shift in one dividend bit per step, keep the quotient bit where it leaves
   always_comb begin
      rem_w  = '0;
      work_w = '0;
      trial  = '0;
      for (int s = 0; s < NSTG; s++) begin
         rem_w  = rem_at[s];
         work_w = work_at[s];
         for (int k = 0; k < STEPS; k++) begin
            if (s * STEPS + k < QW) begin
               trial = {rem_w, work_w[QW-1]};
               if (trial >= DIV_W) begin
                  rem_w  = RW'(trial - DIV_W);
                  work_w = {work_w[QW-2:0], 1'b1};
               end else begin
                  rem_w  = trial[RW-1:0];
                  work_w = {work_w[QW-2:0], 1'b0};
               end
            end
         end
         rem_in[s]  = rem_w;
         work_in[s] = work_w;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_at[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         rem_ff[s]  <= rem_in[s];
         work_ff[s] <= work_in[s];
         side_ff[s] <= side_at[s];
      end
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_quot  = work_ff[NSTG-1];
   assign out_rem   = rem_ff[NSTG-1];
   assign out_side  = side_ff[NSTG-1];

endmodule
